@@ design/jsu_pkg.sv @@
// Shared types, constants and the control store of the Jacobi symbol unit.
// Used by jsu_divmod and jacobi_symbol_unit; depends on nothing else.
`default_nettype none

package jsu_pkg;

	// Operand width of the datapath; fields on the stream ports stay 64 bits.
	localparam int WIDTH  = 64;
	localparam int FieldW = 64;
	localparam int CntW   = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [3:0]       pc_t;

	// Datapath operation carried out in a step.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_ABS,
		OP_HALF,
		OP_RECIP,
		OP_WAIT,
		OP_FINISH,
		OP_BAD
	} op_t;

	// Branch condition tested on the registers before the step's operation.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_BAD,
		C_M_LT2,
		C_M_ODD
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	localparam pc_t PC_CHECK  = 4'd0;
	localparam pc_t PC_ABS    = 4'd1;
	localparam pc_t PC_LOOP   = 4'd2;
	localparam pc_t PC_PARITY = 4'd3;
	localparam pc_t PC_HALF   = 4'd4;
	localparam pc_t PC_RECIP  = 4'd5;
	localparam pc_t PC_WAIT   = 4'd6;
	localparam pc_t PC_FIN    = 4'd7;
	localparam pc_t PC_BAD    = 4'd8;

	// Symbol codes in two's complement.
	localparam logic [1:0] SymZero = 2'b00;
	localparam logic [1:0] SymPos  = 2'b01;
	localparam logic [1:0] SymNeg  = 2'b11;

	// The program. A step performs its operation, then jumps to its target
	// when the condition holds and otherwise falls through to the next step.
	function automatic ctrl_word_t ctrl_rom(input pc_t pc);
		ctrl_word_t cw;
		unique case (pc)
			PC_CHECK:  cw = '{op: OP_NONE,   cond: C_BAD,    target: PC_BAD};
			PC_ABS:    cw = '{op: OP_ABS,    cond: C_NEVER,  target: PC_CHECK};
			PC_LOOP:   cw = '{op: OP_NONE,   cond: C_M_LT2,  target: PC_FIN};
			PC_PARITY: cw = '{op: OP_NONE,   cond: C_M_ODD,  target: PC_RECIP};
			PC_HALF:   cw = '{op: OP_HALF,   cond: C_ALWAYS, target: PC_LOOP};
			PC_RECIP:  cw = '{op: OP_RECIP,  cond: C_NEVER,  target: PC_CHECK};
			PC_WAIT:   cw = '{op: OP_WAIT,   cond: C_ALWAYS, target: PC_LOOP};
			PC_FIN:    cw = '{op: OP_FINISH, cond: C_ALWAYS, target: PC_CHECK};
			PC_BAD:    cw = '{op: OP_BAD,    cond: C_ALWAYS, target: PC_CHECK};
			default:   cw = '{op: OP_BAD,    cond: C_ALWAYS, target: PC_CHECK};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

@@ design/jacobi_symbol_unit.sv @@
// Top level of the Jacobi symbol unit: stream ports, microcoded sequencer and datapath.
// Depends on jsu_pkg (control store, types) and jsu_divmod (remainder unit).
`default_nettype none

// The unit takes one word holding a signed numerator m and an unsigned modulus n and
// returns one word with the Jacobi symbol (m/n) as -1, 0 or +1. A modulus that is even
// or below 3 gives symbol 0 with the bad-modulus flag raised in m_tuser. Only the low
// WIDTH bits of each input field are used. One item is in work at a time; a finished
// result waits in the output register while the next word is accepted. Timing is data
// dependent and set by the step sequencer and the one-bit-per-cycle remainder unit,
// which reduces n mod m in each reciprocity step; setup, finish and each factor of two
// removed from m add sequencer steps. A bad modulus finishes without entering the loop;
// otherwise the worst case is governed by the number of Euclidean steps.
module jacobi_symbol_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [127:0] s_tdata,   // [63:0] value_m, [127:64] modulus_n
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [7:0]   m_tdata,   // [1:0] symbol, [7:2] zero
	output logic         m_tuser    // [0] bad_modulus
);
	import jsu_pkg::*;

	// Sequencer state.
	logic        busy_q;
	pc_t         pc_q;
	ctrl_word_t  cw;
	logic        cond_true;
	logic        hold;

	// Datapath registers: m, n and the running sign of the symbol.
	word_t       m_q;
	word_t       n_q;
	logic        neg_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  sym_q;
	logic        bad_q;

	// Remainder unit.
	logic        div_start;
	logic        div_done;
	word_t       div_rem;

	logic        out_free;
	logic        out_load;
	logic        n_is_one;

	assign cw       = ctrl_rom(pc_q);
	assign out_free = !out_valid_q || m_tready;
	assign n_is_one = (n_q == word_t'(1));

	// A final step loads the output register in this cycle.
	assign out_load = busy_q && out_free && (cw.op == OP_FINISH || cw.op == OP_BAD);

	always_comb begin
		unique case (cw.cond)
			C_NEVER:  cond_true = 1'b0;
			C_ALWAYS: cond_true = 1'b1;
			C_BAD:    cond_true = !n_q[0] || n_is_one;
			C_M_LT2:  cond_true = (m_q[WIDTH-1:1] == '0);
			C_M_ODD:  cond_true = m_q[0];
			default:  cond_true = 1'b0;
		endcase
	end

	// A step holds its place while the remainder unit works, and a final step holds
	// while the previous result still waits in the output register.
	always_comb begin
		unique case (cw.op)
			OP_WAIT:   hold = !div_done;
			OP_FINISH: hold = !out_free;
			OP_BAD:    hold = !out_free;
			default:   hold = 1'b0;
		endcase
	end

	assign div_start = busy_q && (cw.op == OP_RECIP);

	jsu_divmod u_divmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (m_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_CHECK;
			out_valid_q <= 1'b0;
			m_q         <= '0;
			n_q         <= '0;
			neg_q       <= 1'b0;
			sym_q       <= SymZero;
			bad_q       <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (s_tvalid) begin
					m_q    <= s_tdata[WIDTH-1:0];
					n_q    <= s_tdata[FieldW +: WIDTH];
					neg_q  <= 1'b0;
					pc_q   <= PC_CHECK;
					busy_q <= 1'b1;
				end
			end else begin
				unique case (cw.op)
					OP_NONE: begin
					end
					OP_ABS: begin
						// Negation of the most negative value yields its exact magnitude.
						if (m_q[WIDTH-1]) begin
							m_q <= -m_q;
							if (n_q[1:0] == 2'b11) begin
								neg_q <= !neg_q;
							end
						end
					end
					OP_HALF: begin
						m_q <= m_q >> 1;
						if (n_q[2:0] == 3'd3 || n_q[2:0] == 3'd5) begin
							neg_q <= !neg_q;
						end
					end
					OP_RECIP: begin
						if (n_q[1:0] == 2'b11 && m_q[1:0] == 2'b11) begin
							neg_q <= !neg_q;
						end
					end
					OP_WAIT: begin
						if (div_done) begin
							n_q <= m_q;
							m_q <= div_rem;
						end
					end
					OP_FINISH: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							bad_q       <= 1'b0;
							if (m_q == '0) begin
								sym_q <= SymZero;
							end else if (neg_q) begin
								sym_q <= SymNeg;
							end else begin
								sym_q <= SymPos;
							end
							busy_q <= 1'b0;
						end
					end
					OP_BAD: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							bad_q       <= 1'b1;
							sym_q       <= SymZero;
							busy_q      <= 1'b0;
						end
					end
					default: begin
					end
				endcase
				if (!hold) begin
					pc_q <= cond_true ? cw.target : pc_q + pc_t'(1);
				end
			end
		end
	end

	assign s_tready = !busy_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, sym_q};
	assign m_tuser  = bad_q;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> sym_q == SymZero)
		else $error("bad modulus reported with nonzero symbol");

	a_sym_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> sym_q != 2'b10)
		else $error("symbol code out of range");

	a_n_odd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && pc_q != PC_CHECK && pc_q != PC_BAD |-> n_q[0])
		else $error("modulus became even inside the loop");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> busy_q && pc_q == PC_WAIT)
		else $error("remainder finished outside the wait step");

endmodule

`default_nettype wire

@@ design/jsu_divmod.sv @@
// Restoring radix-2 remainder unit: one quotient bit per cycle.
// Depends on jsu_pkg for the operand width.
`default_nettype none

module jsu_divmod (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire jsu_pkg::word_t  dividend,
	input  wire jsu_pkg::word_t  divisor,
	output logic                 done,
	output jsu_pkg::word_t       remainder
);
	import jsu_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	word_t             rem_q;
	word_t             dq_q;
	word_t             d_q;
	logic [WIDTH:0]    rem_sh;
	logic [WIDTH:0]    rem_diff;

	always_comb begin
		rem_sh   = {rem_q, dq_q[WIDTH-1]};
		rem_diff = rem_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dq_q   <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dq_q   <= dividend;
				d_q    <= divisor;
			end else if (busy_q) begin
				// The partial remainder stays below the divisor, so it fits WIDTH bits.
				if (!rem_diff[WIDTH]) begin
					rem_q <= rem_diff[WIDTH-1:0];
				end else begin
					rem_q <= rem_sh[WIDTH-1:0];
				end
				dq_q  <= {dq_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit restarted while busy");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < d_q))
		else $error("remainder not below divisor");

endmodule

`default_nettype wire
